@@ rtl/tbsdp_pkg.sv @@
// Package for the ternary block scaled dot product core.
// Holds the widths, float constants and controller/datapath interface structs.
// No dependencies.
package tbsdp_pkg;

    localparam int BLOCK_ELEMENTS = 32;
    localparam int ACT_WORDS      = 4;
    localparam int ACC_W          = 64;
    localparam int DOT_W          = 16;
    localparam int PSUM_W         = 12;
    localparam int SPROD_W        = 28;
    localparam int NORM_W         = 88;
    localparam int EXP_W          = 10;
    localparam int IN_DATA_W      = 368;

    localparam logic [4:0] HALF_EXP_MAX = 5'h1F;
    localparam logic [7:0] SGL_EXP_MAX  = 8'hFF;
    localparam logic signed [EXP_W-1:0] EXP_MIN    = -10'sd126;
    localparam logic signed [EXP_W-1:0] EXP_MIN8   = -10'sd118;
    localparam logic signed [EXP_W-1:0] EXP_OFFSET = 10'sd87;
    localparam logic signed [EXP_W-1:0] EXP_BIAS   = 10'sd127;
    localparam logic signed [EXP_W-1:0] EXP_INF    = 10'sd255;

    typedef struct packed {
        logic       load;
        logic       dot;
        logic [1:0] word;
        logic       mul;
        logic       acc;
        logic       mag;
        logic       mlo;
        logic       mhi;
        logic       sum;
        logic       norm;
        logic       emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic last;
        logic bad;
        logic norm_done;
        logic out_busy;
    } ctl_status_t;

endpackage

@@ rtl/tbsdp_ctrl.sv @@
// Controller state machine of the ternary block scaled dot product core.
// Sequences the datapath through commands; depends on tbsdp_pkg.
module tbsdp_ctrl
    import tbsdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_DOT  = 10'b00_0000_0010,
        ST_MUL  = 10'b00_0000_0100,
        ST_ACC  = 10'b00_0000_1000,
        ST_CHK  = 10'b00_0001_0000,
        ST_MLO  = 10'b00_0010_0000,
        ST_MHI  = 10'b00_0100_0000,
        ST_SUM  = 10'b00_1000_0000,
        ST_NORM = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.word   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                cmd.dot  = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = status.last ? ST_CHK : ST_IDLE;
            end
            ST_CHK: begin
                cmd.mag    = 1'b1;
                state_next = status.bad ? ST_OUT : ST_MLO;
            end
            ST_MLO: begin
                cmd.mlo    = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI: begin
                cmd.mhi    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (status.norm_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.norm = 1'b1;
                end
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("controller state is not one-hot");
    a_load_dot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_DOT) && (cnt_reg == 2'd0))
        else $error("accepted beat did not start the dot sequence");
    a_norm_live: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.norm |-> !status.norm_done) else $error("normalize step after done");

endmodule

@@ rtl/tbsdp_datapath.sv @@
// Datapath of the ternary block scaled dot product core: dot product,
// scale accumulation, float conversion and the result register.
// Depends on tbsdp_pkg; driven by tbsdp_ctrl.
module tbsdp_datapath
    import tbsdp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  ctl_cmd_t             cmd,
    output ctl_status_t          status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tuser
);

    logic [63:0]                   codes_reg;
    logic [ACT_WORDS-1:0][63:0]    acts_reg;
    logic [15:0]                   hscale_reg;
    logic [31:0]                   row_reg;
    logic                          last_reg;
    logic signed [DOT_W-1:0]       dot_reg;
    logic signed [SPROD_W-1:0]     sprod_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic                          err_reg;
    logic [ACC_W-1:0]              mag_reg;
    logic                          sign_reg;
    logic [55:0]                   plo_reg, phi_reg;
    logic [NORM_W-1:0]             norm_reg;
    logic signed [EXP_W-1:0]       exp_reg;
    logic                          out_valid_reg;
    logic [31:0]                   out_data_reg;
    logic                          out_bad_reg;

    logic [63:0]               word_sel;
    logic [15:0]               code_sel;
    logic signed [PSUM_W-1:0]  psum;
    logic signed [9:0]         term;
    logic signed [7:0]         act;
    logic [4:0]                hexp;
    logic [10:0]               hmag;
    logic signed [11:0]        smant;
    logic [4:0]                hshift;
    logic signed [ACC_W-1:0]   scaled;
    logic [23:0]               row_mant;
    logic [7:0]                row_exp_eff;
    logic [31:0]               mul_op;
    logic [55:0]               mul_res;
    logic                      row_bad;
    logic [23:0]               mant;
    logic                      inc;
    logic [24:0]               mant_rnd;
    logic [23:0]               mant_fin;
    logic signed [EXP_W-1:0]   exp_fin;
    logic signed [EXP_W-1:0]   bexp;
    logic [31:0]               packed_res;

    always_comb begin
        word_sel = acts_reg[cmd.word];
        code_sel = codes_reg[{cmd.word, 4'b0000} +: 16];
        psum     = '0;
        for (int i = 0; i < 8; i++) begin
            act = $signed(word_sel[8*i +: 8]);
            unique case (code_sel[2*i +: 2])
                2'd0:    term = -10'(act);
                2'd1:    term = '0;
                2'd2:    term = 10'(act);
                default: term = 10'(act) <<< 1;
            endcase
            psum = psum + PSUM_W'(term);
        end
    end

    assign hexp   = hscale_reg[14:10];
    assign hmag   = {(hexp != 5'd0), hscale_reg[9:0]};
    assign smant  = hscale_reg[15] ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
    assign hshift = (hexp == 5'd0) ? 5'd0 : hexp - 5'd1;
    assign scaled = ACC_W'(sprod_reg) <<< hshift;

    assign row_exp_eff = (row_reg[30:23] == 8'd0) ? 8'd1 : row_reg[30:23];
    assign row_mant    = {(row_reg[30:23] != 8'd0), row_reg[22:0]};
    assign row_bad     = (row_reg[30:23] == SGL_EXP_MAX);
    assign mul_op      = cmd.mhi ? mag_reg[63:32] : mag_reg[31:0];
    assign mul_res     = 56'(mul_op) * 56'(row_mant);

    always_comb begin
        mant     = norm_reg[87:64];
        inc      = norm_reg[63] & ((|norm_reg[62:0]) | mant[0]);
        mant_rnd = {1'b0, mant} + 25'(inc);
        if (mant_rnd[24]) begin
            mant_fin = mant_rnd[24:1];
            exp_fin  = exp_reg + 10'sd1;
        end else begin
            mant_fin = mant_rnd[23:0];
            exp_fin  = exp_reg;
        end
        bexp = exp_fin + EXP_BIAS;
        if (!mant_fin[23]) begin
            packed_res = {sign_reg, 8'd0, mant_fin[22:0]};
        end else if (bexp >= EXP_INF) begin
            packed_res = {sign_reg, SGL_EXP_MAX, 23'd0};
        end else begin
            packed_res = {sign_reg, bexp[7:0], mant_fin[22:0]};
        end
    end

    assign status.last      = last_reg;
    assign status.bad       = err_reg | row_bad;
    assign status.norm_done = norm_reg[NORM_W-1] | (exp_reg == EXP_MIN);
    assign status.out_busy  = out_valid_reg & ~m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            codes_reg  <= s_tdata[63:0];
            acts_reg   <= s_tdata[319:64];
            hscale_reg <= s_tdata[335:320];
            row_reg    <= s_tdata[367:336];
            last_reg   <= s_tlast;
            dot_reg    <= '0;
        end else if (cmd.dot) begin
            dot_reg <= dot_reg + DOT_W'(psum);
        end
        if (cmd.mul) begin
            sprod_reg <= SPROD_W'(dot_reg) * SPROD_W'(smant);
        end
        if (cmd.mag) begin
            mag_reg  <= acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
            sign_reg <= acc_reg[ACC_W-1] ^ row_reg[31];
        end
        if (cmd.mlo) begin
            plo_reg <= mul_res;
        end
        if (cmd.mhi) begin
            phi_reg <= mul_res;
        end
        if (cmd.sum) begin
            norm_reg <= {phi_reg, 32'd0} + NORM_W'(plo_reg);
            exp_reg  <= $signed({2'b00, row_exp_eff}) - EXP_OFFSET;
        end else if (cmd.norm) begin
            if ((norm_reg[87:80] == 8'd0) && (exp_reg >= EXP_MIN8)) begin
                norm_reg <= {norm_reg[79:0], 8'd0};
                exp_reg  <= exp_reg - 10'sd8;
            end else begin
                norm_reg <= {norm_reg[86:0], 1'b0};
                exp_reg  <= exp_reg - 10'sd1;
            end
        end
        if (cmd.emit) begin
            out_data_reg <= status.bad ? 32'd0 : packed_res;
            out_bad_reg  <= status.bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                acc_reg <= '0;
                err_reg <= 1'b0;
            end else if (cmd.acc) begin
                if (hexp == HALF_EXP_MAX) begin
                    err_reg <= 1'b1;
                end else begin
                    acc_reg <= acc_reg + scaled;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_tvalid && !m_tready)) else $error("result overwritten");
    a_emit_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (acc_reg == '0) && !err_reg && m_tvalid)
        else $error("state not cleared after result");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'd0)) else $error("bad result not zero");

endmodule

@@ rtl/ternary_block_scaled_dot_product_core.sv @@
// After a beat without tlast is accepted, the dot product steps over the four activation words,
// then come the scale multiply and the accumulate, and the controller returns to idle for the next beat.
// A last block adds the magnitude step, the low and high row-scale multiplies, the sum and a normalize
// loop of 8- or 1-bit shifts, or jumps from the magnitude step to the output if a scale is non-finite.
// A finished result waits in the output register while the next block is accepted.
// Synchronous active-low reset idles the controller and clears the accumulator, error flag and output valid.
module ternary_block_scaled_dot_product_core
    import tbsdp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // weight_codes, acts_a, acts_b, acts_c, acts_d, block_scale, row_scale
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_bits
    output logic [31:0]          m_tdata,
    // bad_scale
    output logic                 m_tuser
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    tbsdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tbsdp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
